### sv/imconv_pkg.sv
// package: sizes, beat layouts and helpers for the 2d image convolution block
`timescale 1ns / 1ps
package imconv_pkg;
  localparam int unsigned MaxRadius = 4;
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned PixelBits = 16;
  localparam int unsigned CoefBits = 18;
  localparam int unsigned WinSide = 2 * MaxRadius + 1;
  localparam int unsigned RowsKept = 2 * MaxRadius;
  localparam int unsigned KernelDepth = WinSide * WinSide;
  localparam int unsigned ColBits = $clog2(MaxWidth);
  localparam int unsigned RowBits = $clog2(MaxHeight);
  localparam int unsigned SlotBits = $clog2(RowsKept);
  localparam int unsigned KIdxBits = $clog2(KernelDepth);
  localparam int unsigned ProdBits = PixelBits + CoefBits;
  localparam int unsigned AccBits = ProdBits + $clog2(KernelDepth) + 1;
  localparam int unsigned OutBits = 24;
  localparam int unsigned InDataBits = 48;
  localparam int unsigned OutDataBits = 48;

  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegWidth = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  typedef logic signed [PixelBits-1:0] pixel_t;
  typedef logic signed [CoefBits-1:0] coef_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [AccBits-1:0] acc_t;

  // one accepted pixel that completes a window
  typedef struct packed {
    logic [RowBits-1:0] row;
    logic [ColBits-1:0] col;
    logic last;
  } tag_t;
endpackage

### sv/imconv_mac.sv
// multiply-accumulate pipeline: window times kernel, rounding and saturation
`timescale 1ns / 1ps
module imconv_mac (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [2:0] radius_i,
  input  imconv_pkg::pixel_t win_i [imconv_pkg::KernelDepth],
  input  imconv_pkg::coef_t coef_i [imconv_pkg::KernelDepth],
  input  imconv_pkg::tag_t tag_i,
  output logic valid_o,
  output logic signed [imconv_pkg::OutBits-1:0] value_o,
  output imconv_pkg::tag_t tag_o
);
  import imconv_pkg::*;

  localparam int unsigned Groups = WinSide;

  prod_t prod_q [KernelDepth];
  acc_t row_q [Groups];
  acc_t sum_q;
  tag_t tag1_q, tag2_q, tag3_q;
  logic [2:0] vld_q;
  logic [3:0] base;

  assign base = 4'(WinSide - 1) - {radius_i, 1'b0};

  // products: window tap (base+ky, base+kx) with coefficient (ky, kx)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ky = 0; ky < WinSide; ky++) begin
        for (int kx = 0; kx < WinSide; kx++) begin
          if (ky >= int'(base) && kx >= int'(base)) begin
            prod_q[ky*WinSide+kx] <= win_i[ky*WinSide+kx]
              * coef_i[(ky-int'(base))*WinSide+(kx-int'(base))];
          end else begin
            prod_q[ky*WinSide+kx] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < Groups; g++) begin
        acc_t s;
        s = '0;
        for (int k = 0; k < WinSide; k++) s = s + AccBits'(prod_q[g*WinSide+k]);
        row_q[g] <= s;
      end
      begin
        acc_t t;
        t = '0;
        for (int g = 0; g < Groups; g++) t = t + row_q[g];
        sum_q <= t + acc_t'(1 << 15);
      end
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  acc_t shifted;
  assign shifted = sum_q >>> 16;
  always_comb begin
    if (shifted > acc_t'(8388607)) value_o = 24'sh7FFFFF;
    else if (shifted < -acc_t'(8388608)) value_o = 24'sh800000;
    else value_o = shifted[OutBits-1:0];
  end
  assign valid_o = vld_q[2];
  assign tag_o = tag3_q;
endmodule

### sv/image_convolution_2d.sv
// top level: streaming 2d convolution with row memory, window and kernel store
//
// channel  | dir | contents
// s_axis   | in  | tdata {coef_value, coef_index, pixel_value}, tuser mode
// m_axis   | out | tdata {out_col, out_row, out_value}, tlast last_of_frame
// cfg      | in  | index 0 radius, 1 width, 2 height
//
// one beat per cycle while no stalled result is held; a result is presented after
// the row memory read, which lands with the accept, then the window load, three mac
// stages and the output register
// stall on the output freezes the whole pipeline, so s_axis_tready follows
// m_axis_tready when a result is held; reset clears counters, window, kernel
`timescale 1ns / 1ps
module image_convolution_2d (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pixel_value[15:0], coef_index[22:16], coef_value[40:23], zeros
  input  logic [47:0] s_axis_tdata,
  // mode
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_value[23:0], out_row[35:24], out_col[45:36], zeros
  output logic [47:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import imconv_pkg::*;

  logic [2:0] radius_q;
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [RowBits-1:0] row_q;
  logic [ColBits:0] col_q;
  logic [SlotBits-1:0] slot_q;

  pixel_t win_q [KernelDepth];
  coef_t kern_q [KernelDepth];
  // one word per column holds that column of every kept row
  logic [RowsKept-1:0][PixelBits-1:0] mem [MaxWidth];
  logic [RowsKept-1:0][PixelBits-1:0] rd_q;
  logic [RowsKept-1:0][PixelBits-1:0] wb_data;
  logic wb_q;

  logic en, take, pix;
  logic s1_valid_q;
  logic [SlotBits-1:0] s1_slot_q;
  logic [ColBits-1:0] s1_col_q;
  pixel_t s1_pix_q;
  tag_t s1_tag_q;
  logic s1_full_q;
  logic [2:0] r_eff;
  logic [ColBits:0] w_eff;
  logic [RowBits:0] h_eff;

  logic mac_v;
  logic signed [OutBits-1:0] mac_val;
  tag_t mac_tag;
  logic out_v_q;
  logic [47:0] out_data_q;
  logic out_last_q;

  assign cfg_ready_o = 1'b1;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign take = s_axis_tvalid && en;
  assign pix = take && !s_axis_tuser;

  assign r_eff = (radius_q == 3'd0) ? 3'd1 : (radius_q > 3'(MaxRadius) ? 3'(MaxRadius)
                                                                        : radius_q);
  assign w_eff = (width_q == 11'd0) ? 11'd1 : (width_q > 11'(MaxWidth) ? 11'(MaxWidth)
                                                                        : width_q);
  assign h_eff = (height_q == 13'd0) ? 13'd1 : (height_q > 13'(MaxHeight) ? 13'(MaxHeight)
                                                                          : height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 3'd1;
      width_q <= 11'd1024;
      height_q <= 13'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRadius: radius_q <= cfg_data_i[2:0];
        RegWidth:  width_q <= cfg_data_i[10:0];
        RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // kernel store: a write is held in a register before it lands, so the pixel
  // ahead of it still multiplies with the old kernel
  logic [6:0] kidx;
  logic kw_q;
  logic [6:0] kw_idx_q;
  coef_t kw_val_q;
  assign kidx = s_axis_tdata[22:16];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KernelDepth; i++) kern_q[i] <= '0;
      kw_q <= 1'b0;
    end else if (en) begin
      kw_q <= take && s_axis_tuser && kidx < 7'(KernelDepth);
      if (kw_q) kern_q[kw_idx_q] <= kw_val_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (take && s_axis_tuser) begin
      kw_idx_q <= kidx;
      kw_val_q <= s_axis_tdata[40:23];
    end
  end

  // counters
  logic full, last;
  logic [RowBits:0] row_n;
  assign row_n = {1'b0, row_q} + 1'b1;
  assign full = ({1'b0, row_q} >= {r_eff, 1'b0}) && (col_q >= {r_eff, 1'b0})
                && ({1'b0, row_q} < h_eff) && (col_q < w_eff);
  assign last = (row_n == h_eff) && (col_q + 1'b1 == w_eff);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      slot_q <= '0;
    end else if (pix) begin
      if (col_q + 1'b1 >= w_eff) begin
        col_q <= '0;
        row_q <= (row_n >= h_eff) ? '0 : row_n[RowBits-1:0];
        slot_q <= (row_n >= h_eff) ? '0 : row_n[SlotBits-1:0];
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // row memory: read the column word on accept, write it back in the following cycle
  // with the new pixel in its slot; forward when the next beat reads it
  always_comb begin
    wb_data = rd_q;
    wb_data[s1_slot_q] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= 1'b0;
    end else begin
      wb_q <= pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_q) mem[s1_col_q] <= wb_data;
    if (pix) begin
      if (wb_q && s1_col_q == col_q[ColBits-1:0]) rd_q <= wb_data;
      else rd_q <= mem[col_q[ColBits-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= pix;
    end
  end
  always_ff @(posedge clk_i) begin
    if (pix) begin
      s1_slot_q <= slot_q;
      s1_col_q <= col_q[ColBits-1:0];
      s1_pix_q <= s_axis_tdata[15:0];
      s1_full_q <= full;
      s1_tag_q.row <= row_q - RowBits'(r_eff);
      s1_tag_q.col <= col_q[ColBits-1:0] - ColBits'(r_eff);
      s1_tag_q.last <= last;
    end
  end

  // window shift, loaded from the registered column word of the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KernelDepth; i++) win_q[i] <= '0;
    end else if (en && s1_valid_q) begin
      for (int dy = 0; dy < WinSide; dy++) begin
        for (int dx = 0; dx < WinSide - 1; dx++) begin
          win_q[dy*WinSide+dx] <= win_q[dy*WinSide+dx+1];
        end
      end
      for (int dy = 0; dy < WinSide - 1; dy++) begin
        logic [SlotBits-1:0] s;
        s = s1_slot_q - SlotBits'(WinSide - 1 - dy);
        win_q[dy*WinSide+WinSide-1] <= rd_q[s];
      end
      win_q[KernelDepth-1] <= s1_pix_q;
    end
  end

  logic s2_valid_q;
  tag_t s2_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (en) s2_valid_q <= s1_valid_q && s1_full_q;
  end
  always_ff @(posedge clk_i) if (en) s2_tag_q <= s1_tag_q;

  imconv_mac u_mac (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_valid_q), .radius_i(r_eff),
    .win_i(win_q), .coef_i(kern_q), .tag_i(s2_tag_q),
    .valid_o(mac_v), .value_o(mac_val), .tag_o(mac_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= mac_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {2'b0, mac_tag.col, mac_tag.row, mac_val};
      out_last_q <= mac_tag.last;
    end
  end
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tlast = out_last_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline frozen");
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= {1'b0, 10'h3FF} + 1'b1)
    else $error("column counter out of range");
endmodule

### bench/tb.sv
// testbench: image_convolution_2d against a cycle-free convolution predictor
`timescale 1ns / 1ps
module tb;
  import imconv_pkg::*;

  typedef struct {
    logic mode;
    logic signed [15:0] pix;
    logic [6:0] cidx;
    logic signed [17:0] cval;
  } in_beat_t;

  typedef struct {
    logic [23:0] val;
    logic [11:0] row;
    logic [9:0] col;
    logic last;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = RegRadius;
  logic [12:0] cfg_data_i = '0;

  image_convolution_2d dut (.*);

  // predictor state
  pixel_t line_mem [RowsKept*MaxWidth];
  pixel_t win [KernelDepth];
  coef_t kern [KernelDepth];
  int unsigned row_cnt, col_cnt;
  int unsigned radius_reg = 1, width_reg = 1024, height_reg = 1024;

  in_beat_t pending_beats[$];
  conv_result_t results_due[$];
  int fails = 0;
  int src_idle = 0, snk_idle = 0;
  bit beat_taken = 1'b0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic convolve_beat(in_beat_t b);
    int unsigned r, w, h, row, col, slot, base;
    bit full, last;
    longint acc, q;
    conv_result_t e;
    if (b.mode) begin
      if (b.cidx < KernelDepth) kern[b.cidx] = b.cval;
      return;
    end
    r = clampu(radius_reg, 1, MaxRadius);
    w = clampu(width_reg, 1, MaxWidth);
    h = clampu(height_reg, 1, MaxHeight);
    row = row_cnt;
    col = col_cnt;
    for (int dy = 0; dy < WinSide; dy++)
      for (int dx = 0; dx < WinSide - 1; dx++)
        win[dy*WinSide+dx] = win[dy*WinSide+dx+1];
    slot = row % RowsKept;
    // column fed from the stored rows, oldest at the top
    for (int dy = 0; dy < WinSide - 1; dy++)
      win[dy*WinSide+WinSide-1] = (col < MaxWidth) ?
          line_mem[((slot + dy) % RowsKept)*MaxWidth+col] : '0;
    win[KernelDepth-1] = b.pix;
    if (col < MaxWidth) line_mem[slot*MaxWidth+col] = b.pix;
    full = row >= 2*r && col >= 2*r && row < h && col < w;
    last = row + 1 == h && col + 1 == w;
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
    if (!full) return;
    base = WinSide - 1 - 2*r;
    acc = 0;
    for (int ky = 0; ky <= 2*r; ky++)
      for (int kx = 0; kx <= 2*r; kx++)
        acc += longint'(win[(base+ky)*WinSide+base+kx]) * longint'(kern[ky*WinSide+kx]);
    q = (acc + 64'sd32768) >>> 16;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    e.val = q[23:0];
    e.row = 12'(row - r);
    e.col = 10'(col - r);
    e.last = last;
    results_due.insert(results_due.size(), e);
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // input side: predict on each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      convolve_beat(pending_beats[0]);
      void'(pending_beats.pop_front());
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || beat_taken) begin
      beat_taken = 1'b0;
      if (rst_ni && pending_beats.size() > 0 && $urandom_range(99) >= src_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, pending_beats[0].cval, pending_beats[0].cidx,
                         pending_beats[0].pix};
        s_axis_tuser <= pending_beats[0].mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_idle);
  end

  // output side
  always @(posedge clk_i) begin
    conv_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        fails++;
      end else begin
        e = results_due.pop_front();
        if (m_axis_tdata[23:0] !== e.val) begin
          $error("out_value exp %h got %h", e.val, m_axis_tdata[23:0]);
          fails++;
        end
        if (m_axis_tdata[35:24] !== e.row) begin
          $error("out_row exp %0d got %0d", e.row, m_axis_tdata[35:24]);
          fails++;
        end
        if (m_axis_tdata[45:36] !== e.col) begin
          $error("out_col exp %0d got %0d", e.col, m_axis_tdata[45:36]);
          fails++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_of_frame exp %b got %b", e.last, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[12:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegRadius: radius_reg = val & 32'h7;
      RegWidth:  width_reg = val & 32'h7FF;
      RegHeight: height_reg = val & 32'h1FFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_coef(int unsigned idx, int v);
    in_beat_t b;
    b.mode = 1'b1;
    b.pix = 16'($urandom);
    b.cidx = idx[6:0];
    b.cval = v[17:0];
    pending_beats.insert(pending_beats.size(), b);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // whole frame in raster order, coefficient beats mixed in at random
  task automatic queue_frame(int unsigned w, int unsigned h, int unsigned coef_pct);
    in_beat_t b;
    for (int unsigned i = 0; i < w*h; i++) begin
      if ($urandom_range(99) < coef_pct)
        queue_coef($urandom_range(99) < 90 ? $urandom_range(80) : $urandom_range(127),
                   int'($urandom));
      b.mode = 1'b0;
      b.pix = pick_pixel();
      b.cidx = 7'($urandom);
      b.cval = 18'($urandom);
      pending_beats.insert(pending_beats.size(), b);
    end
  endtask

  // sender holds off until the block has drained, then the pipeline settles
  task automatic drain();
    while (pending_beats.size() > 0 || results_due.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic setup(int unsigned r, int unsigned w, int unsigned h);
    cfg_write(RegRadius, r);
    cfg_write(RegWidth, w);
    cfg_write(RegHeight, h);
  endtask

  initial begin
    int unsigned r, w, h, sent;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    foreach (kern[i]) kern[i] = '0;
    row_cnt = 0;
    col_cnt = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: radius zero counts as one, smallest frame, extreme taps
    setup(0, 3, 3);
    for (int i = 0; i < 9; i++) queue_coef(i, (i % 2) ? -131072 : 131071);
    queue_coef(80, -1);
    queue_coef(81, 12345);
    queue_coef(127, -5);
    queue_frame(3, 3, 0);
    drain();
    // radius above the maximum, full 9x9 kernel
    setup(7, 9, 9);
    for (int i = 0; i < 81; i++) queue_coef(i, int'($urandom));
    queue_frame(9, 9, 0);
    drain();
    // zero sizes act as one pixel
    setup(1, 0, 0);
    queue_frame(1, 1, 0);
    queue_frame(1, 1, 0);
    drain();
    // row narrower than the kernel never gives a result
    setup(4, 5, 12);
    queue_frame(5, 12, 5);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0; snk_idle = 0; end
        1: begin src_idle = 84; snk_idle = 0; end
        2: begin src_idle = 0; snk_idle = 84; end
        default: begin src_idle = 37; snk_idle = 37; end
      endcase
      sent = 0;
      while (sent < 270) begin
        r = $urandom_range(1, 4);
        w = $urandom_range(2*r + 1, 2*r + 8);
        h = $urandom_range(2*r + 1, 2*r + 5);
        cfg_write(RegRadius, ($urandom_range(9) == 0) ? (r == 1 ? 0 : 7 - (4 - r)) : r);
        if (r == 4 && radius_reg != 4) radius_reg = radius_reg; // 5..7 all clamp to 4
        r = clampu(radius_reg, 1, MaxRadius);
        if (w < 2*r + 1) w = 2*r + 1;
        if (h < 2*r + 1) h = 2*r + 1;
        cfg_write(RegWidth, w);
        cfg_write(RegHeight, h);
        if ($urandom_range(3) == 0)
          for (int i = 0; i < 81; i++) queue_coef(i, int'($urandom));
        queue_frame(w, h, 6);
        sent += pending_beats.size();
        drain();
      end
    end
    src_idle = 0;
    snk_idle = 0;
    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("image_convolution_2d: match");
    end else begin
      $display("image_convolution_2d: mismatch");
    end
    $finish;
  end

  initial begin
    #(8 * 3_000_000);
    $display("image_convolution_2d: mismatch");
    $finish;
  end
endmodule
